@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the divergence alert block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hdl/dpda_pkg.sv @@
// Package for the dual position divergence alert: payload structs, UBX frame
// constants and the status bundle from each parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpda_pkg;

    // Request payload: one sample of both receiver byte lanes.
    typedef struct packed {
        logic [7:0] byte_a;
        logic       strobe_a;
        logic [7:0] byte_b;
        logic       strobe_b;
    } in_t;

    // Result payload.
    typedef struct packed {
        logic alarm;
        logic fix_a;
        logic fix_b;
    } out_t;

    typedef logic [5:0]       pos_t;
    typedef logic [2:0][31:0] xyz_t;

    // Status of one receiver parser as seen by the distance pipeline.
    typedef struct packed {
        xyz_t held;
        logic fix;
        pos_t pos;
    } rx_status_t;

    localparam logic [30:0] ALERT_RESET = 31'd100;

    // UBX NAV-SOL header bytes.
    localparam logic [7:0] UBX_SYNC1  = 8'd181;
    localparam logic [7:0] UBX_SYNC2  = 8'd98;
    localparam logic [7:0] UBX_CLASS  = 8'h01;
    localparam logic [7:0] UBX_ID     = 8'h06;
    localparam logic [7:0] UBX_LEN_LO = 8'd52;
    localparam logic [7:0] UBX_LEN_HI = 8'h00;

    // Valid fix types (2D, 3D, GNSS plus dead reckoning).
    localparam logic [7:0] FIX_MIN = 8'd2;
    localparam logic [7:0] FIX_MAX = 8'd4;

    // Byte positions within a frame.
    localparam pos_t POS_SYNC1       = 6'd0;
    localparam pos_t POS_SYNC2       = 6'd1;
    localparam pos_t POS_CLASS       = 6'd2;
    localparam pos_t POS_ID          = 6'd3;
    localparam pos_t POS_LEN_LO      = 6'd4;
    localparam pos_t POS_LEN_HI      = 6'd5;
    localparam pos_t POS_PAY         = 6'd6;
    localparam pos_t POS_PRE_FIX_END = 6'd15;
    localparam pos_t POS_FIX         = 6'd16;
    localparam pos_t POS_FLAGS       = 6'd17;
    localparam pos_t POS_X           = 6'd18;
    localparam pos_t POS_XYZ_END     = 6'd29;
    localparam pos_t POS_TAIL        = 6'd30;
    localparam pos_t POS_PAY_LAST    = 6'd57;
    localparam pos_t POS_CKA         = 6'd58;
    localparam pos_t POS_CKB         = 6'd59;

endpackage

`default_nettype wire

@@ hdl/ubx_dual_position_divergence_alert_unit.sv @@
// Top level of the dual UBX position divergence alert: input register,
// two receiver parsers and the distance pipeline. Uses dpda_pkg and
// assert_macros.svh.
//
//  Channel   Ports                          Carries
//  request   s_valid s_ready s_data (in_t)  both byte lanes and strobe levels
//  result    m_valid m_ready m_data (out_t) alarm, fix_a, fix_b
//  config    cfg_we cfg_wdata[30:0]         alert distance in cm
//
// One request is taken per cycle while s_ready is high; it passes through
// six register stages (input, parse, difference, square, sum, result),
// with the 31 x 31 square as the widest step.
// Reset is synchronous: parser state and held positions clear and the
// threshold returns to 100 cm. A stalled result holds only its own stage;
// upstream stages keep accepting until they fill.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ubx_dual_position_divergence_alert_unit
    import dpda_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata
);

    logic [30:0] alert_reg;
    in_t         in_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        pipe_ready;
    logic        rdy2;
    logic        parse_step;
    rx_status_t  st_a, st_b;

    // Stage handshakes.
    assign rdy2       = !v2_reg || pipe_ready;
    assign parse_step = v1_reg && rdy2;
    assign s_ready    = !v1_reg || rdy2;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alert_reg <= ALERT_RESET;
        end else if (cfg_we) begin
            alert_reg <= cfg_wdata;
        end
    end

    // Input and parse stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_ready) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // One parser per receiver; both step as the request enters the parse stage.
    dpda_ubx_parser u_parser_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (parse_step),
        .strobe  (in_reg.strobe_a),
        .rx_byte (in_reg.byte_a),
        .status  (st_a)
    );

    dpda_ubx_parser u_parser_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (parse_step),
        .strobe  (in_reg.strobe_b),
        .rx_byte (in_reg.byte_b),
        .status  (st_b)
    );

    // Distance and threshold pipeline.
    dpda_alarm_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .alert_cm (alert_reg),
        .in_valid (v2_reg),
        .in_ready (pipe_ready),
        .st_a     (st_a),
        .st_b     (st_b),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Parsers never run past the second checksum byte.
    `ASSERT_NEVER(a_pos_a_range, aclk, aresetn, st_a.pos > POS_CKB, "parser A position out of frame")
    `ASSERT_NEVER(a_pos_b_range, aclk, aresetn, st_b.pos > POS_CKB, "parser B position out of frame")
    // Held positions only change when a request enters the parse stage.
    `ASSERT_PROP(a_held_stable, aclk, aresetn, !parse_step |=> $stable(st_a.held) && $stable(st_b.held), "held position changed without a request")

endmodule

`default_nettype wire

@@ hdl/dpda_ubx_parser.sv @@
// UBX NAV-SOL parser for one receiver: strobe edge detect, Fletcher-8
// checksum, fix flag, ECEF assembly and held position. Uses dpda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpda_ubx_parser
    import dpda_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic       strobe,
    input  wire logic [7:0] rx_byte,
    output rx_status_t      status
);

    logic       last_strobe_reg, last_strobe_next;
    pos_t       pos_reg, pos_next;
    logic [7:0] ck_a_reg, ck_a_next;
    logic [7:0] ck_b_reg, ck_b_next;
    xyz_t       partial_reg, partial_next;
    xyz_t       held_reg, held_next;
    logic       fix_reg, fix_next;

    logic       take;
    logic       seq_ok;
    pos_t       pos_off;
    logic [3:0] idx;

    // A byte is taken when the strobe level differs from the last one seen.
    assign take    = step && (strobe != last_strobe_reg);
    assign pos_off = pos_reg - POS_X;
    assign idx     = pos_off[3:0];

    // Bytes that simply move the frame forward.
    assign seq_ok = (pos_reg == POS_SYNC1  && rx_byte == UBX_SYNC1)  ||
                    (pos_reg == POS_SYNC2  && rx_byte == UBX_SYNC2)  ||
                    (pos_reg == POS_CLASS  && rx_byte == UBX_CLASS)  ||
                    (pos_reg == POS_ID     && rx_byte == UBX_ID)     ||
                    (pos_reg == POS_LEN_LO && rx_byte == UBX_LEN_LO) ||
                    (pos_reg == POS_LEN_HI && rx_byte == UBX_LEN_HI) ||
                    (pos_reg inside {[POS_PAY:POS_PRE_FIX_END]})     ||
                    (pos_reg inside {[POS_TAIL:POS_PAY_LAST]})       ||
                    (pos_reg == POS_CKA && rx_byte == ck_a_reg)      ||
                    (pos_reg == POS_FLAGS);

    // Next-state logic for one received byte.
    always_comb begin
        last_strobe_next = last_strobe_reg;
        pos_next         = pos_reg;
        ck_a_next        = ck_a_reg;
        ck_b_next        = ck_b_reg;
        partial_next     = partial_reg;
        held_next        = held_reg;
        fix_next         = fix_reg;

        if (take) begin
            last_strobe_next = strobe;

            // Checksum runs over class through payload and holds on the
            // checksum bytes themselves.
            if (pos_reg inside {[POS_CLASS:POS_PAY_LAST]}) begin
                ck_a_next = ck_a_reg + rx_byte;
                ck_b_next = ck_b_reg + ck_a_next;
            end else if (pos_reg != POS_CKA && pos_reg != POS_CKB) begin
                ck_a_next = '0;
                ck_b_next = '0;
            end

            if (seq_ok) begin
                pos_next = pos_reg + 6'd1;
            end else if (pos_reg == POS_FIX) begin
                if (rx_byte >= FIX_MIN && rx_byte <= FIX_MAX) begin
                    pos_next = pos_reg + 6'd1;
                    fix_next = 1'b1;
                end else begin
                    pos_next     = '0;
                    partial_next = '0;
                    fix_next     = 1'b0;
                end
            end else if (pos_reg inside {[POS_X:POS_XYZ_END]}) begin
                // Little-endian coordinate bytes, four per axis.
                partial_next[idx[3:2]] = partial_reg[idx[3:2]] |
                                         (32'(rx_byte) << {idx[1:0], 3'b000});
                pos_next = pos_reg + 6'd1;
            end else if (pos_reg == POS_CKB && rx_byte == ck_b_reg) begin
                // Frame is good: commit the assembled position.
                held_next    = partial_reg;
                pos_next     = '0;
                partial_next = '0;
            end else begin
                pos_next     = '0;
                partial_next = '0;
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_strobe_reg <= 1'b0;
            pos_reg         <= '0;
            ck_a_reg        <= '0;
            ck_b_reg        <= '0;
            partial_reg     <= '0;
            held_reg        <= '0;
            fix_reg         <= 1'b0;
        end else begin
            last_strobe_reg <= last_strobe_next;
            pos_reg         <= pos_next;
            ck_a_reg        <= ck_a_next;
            ck_b_reg        <= ck_b_next;
            partial_reg     <= partial_next;
            held_reg        <= held_next;
            fix_reg         <= fix_next;
        end
    end

    assign status.held = held_reg;
    assign status.fix  = fix_reg;
    assign status.pos  = pos_reg;

endmodule

`default_nettype wire

@@ hdl/dpda_alarm_pipe.sv @@
// Distance pipeline: coordinate differences, squares, sum and threshold
// compare, ending in the result register. Uses dpda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpda_alarm_pipe
    import dpda_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [30:0] alert_cm,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  rx_status_t       st_a,
    input  rx_status_t       st_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    // Square of threshold plus one, recomputed every cycle from the register.
    logic [31:0] lim_reg;
    logic [63:0] lim2_reg;

    // Difference stage.
    logic              v3_reg;
    logic [2:0][30:0]  mag_reg, mag_next;
    logic              big3_reg, big3_next;
    logic [1:0]        fix3_reg;

    // Square stage.
    logic              v4_reg;
    logic [2:0][61:0]  sq_reg;
    logic              big4_reg;
    logic [1:0]        fix4_reg;

    // Sum stage.
    logic              v5_reg;
    logic [63:0]       sum_reg;
    logic              big5_reg;
    logic [1:0]        fix5_reg;

    // Result register.
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic rdy_out, rdy5, rdy4, rdy3;
    logic signed [32:0] diff [3];
    logic        [32:0] mag_full [3];

    // Each stage moves on when the next one is empty or moving.
    assign rdy_out  = !m_valid_reg || m_ready;
    assign rdy5     = !v5_reg || rdy_out;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    // Signed differences and magnitudes; anything at or above 2^31 alarms.
    always_comb begin
        big3_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            diff[k] = $signed({st_a.held[k][31], st_a.held[k]}) -
                      $signed({st_b.held[k][31], st_b.held[k]});
            mag_full[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
            mag_next[k] = mag_full[k][30:0];
            big3_next   = big3_next | mag_full[k][32] | mag_full[k][31];
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg  <= {1'b0, alert_cm} + 32'd1;
        lim2_reg <= 64'(lim_reg) * 64'(lim_reg);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy3) v3_reg <= in_valid;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy_out) m_valid_reg <= v5_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            mag_reg  <= mag_next;
            big3_reg <= big3_next;
            fix3_reg <= {st_a.fix, st_b.fix};
        end
        if (rdy4) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= 62'(mag_reg[k]) * 62'(mag_reg[k]);
            end
            big4_reg <= big3_reg;
            fix4_reg <= fix3_reg;
        end
        if (rdy5) begin
            sum_reg  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            big5_reg <= big4_reg;
            fix5_reg <= fix4_reg;
        end
        if (rdy_out) begin
            m_data_reg.alarm <= big5_reg || (sum_reg >= lim2_reg);
            m_data_reg.fix_a <= fix5_reg[1];
            m_data_reg.fix_b <= fix5_reg[0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_ubx_dual_position_divergence_alert_unit.sv @@
// Self-checking testbench for the dual UBX position divergence alert unit.
// Drives sampled byte lanes of two receivers and checks alarm and fix flags
// against a behavioral predictor. Depends on dpda_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_ubx_dual_position_divergence_alert_unit;
    import dpda_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam int unsigned PHASE_NEW_BYTES  = 140;
    localparam int unsigned TAIL_CYCLES      = 20;
    localparam longint      HALF_RANGE       = 64'sd1073741823;

    // Kinds of frame the stream generator can emit.
    typedef enum int {
        FRM_GOOD,
        FRM_BAD_HDR,
        FRM_BAD_FIX,
        FRM_BAD_CKA,
        FRM_BAD_CKB,
        FRM_CUT
    } frame_kind_e;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_we    = 1'b0;
    logic [30:0] cfg_wdata = '0;

    // Request and prediction queues.
    in_t  pending_samples[$];
    out_t predicted_status[$];

    // Byte streams waiting to be serialized onto each lane.
    logic [7:0] lane_a_bytes[$];
    logic [7:0] lane_b_bytes[$];
    logic       strobe_a_level = 1'b0;
    logic       strobe_b_level = 1'b0;

    // Predictor state for both receivers.
    logic [30:0] alert_cm_model;
    logic        lane_strobe [2];
    pos_t        frame_pos   [2];
    logic [7:0]  sum_a       [2];
    logic [7:0]  sum_b       [2];
    logic [31:0] partial_xyz [2][3];
    logic [31:0] held_xyz    [2][3];
    logic        fix_seen    [2];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned samples_sent     = 0;
    int unsigned new_byte_samples = 0;
    int unsigned results_seen     = 0;
    int unsigned mismatches       = 0;
    int unsigned alarms_seen      = 0;
    int unsigned frames_good      = 0;
    int unsigned frames_broken    = 0;
    int unsigned cycle_count      = 0;
    out_t        mon_want;

    ubx_dual_position_divergence_alert_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock generation, 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Drop the frame in progress on one receiver.
    function automatic void lane_abort(int r);
        frame_pos[r] = POS_SYNC1;
        for (int k = 0; k < 3; k++) partial_xyz[r][k] = '0;
    endfunction

    // Advance one receiver's frame parser by one byte.
    function automatic void lane_take_byte(int r, logic [7:0] b);
        pos_t p;
        int   k;
        bit   advance;
        p = frame_pos[r];
        if (p >= POS_CLASS && p <= POS_PAY_LAST) begin
            sum_a[r] = sum_a[r] + b;
            sum_b[r] = sum_b[r] + sum_a[r];
        end else if (p != POS_CKA && p != POS_CKB) begin
            sum_a[r] = '0;
            sum_b[r] = '0;
        end
        advance = (p == POS_SYNC1 && b == UBX_SYNC1) || (p == POS_SYNC2 && b == UBX_SYNC2) ||
                  (p == POS_CLASS && b == UBX_CLASS) || (p == POS_ID && b == UBX_ID) ||
                  (p == POS_LEN_LO && b == UBX_LEN_LO) || (p == POS_LEN_HI && b == UBX_LEN_HI) ||
                  (p >= POS_PAY && p <= POS_PRE_FIX_END) ||
                  (p >= POS_TAIL && p <= POS_PAY_LAST) ||
                  (p == POS_CKA && b == sum_a[r]) || p == POS_FLAGS;
        if (advance) begin
            frame_pos[r] = p + 1'b1;
        end else if (p == POS_FIX) begin
            if (b >= FIX_MIN && b <= FIX_MAX) begin
                frame_pos[r] = p + 1'b1;
                fix_seen[r] = 1'b1;
            end else begin
                lane_abort(r);
                fix_seen[r] = 1'b0;
            end
        end else if (p >= POS_X && p <= POS_XYZ_END) begin
            k = (p - POS_X) / 4;
            partial_xyz[r][k] = partial_xyz[r][k] | (32'(b) << (8 * ((p - POS_X) % 4)));
            frame_pos[r] = p + 1'b1;
        end else if (p == POS_CKB && b == sum_b[r]) begin
            for (int j = 0; j < 3; j++) held_xyz[r][j] = partial_xyz[r][j];
            lane_abort(r);
        end else begin
            lane_abort(r);
        end
    endfunction

    // Exact check of squared distance against (threshold + 1) squared.
    function automatic logic divergence_alarm();
        logic [63:0] lim;
        logic [63:0] lim2;
        logic [63:0] total;
        logic [63:0] mag;
        longint      diff;
        lim = 64'(alert_cm_model) + 64'd1;
        lim2 = lim * lim;
        total = '0;
        for (int k = 0; k < 3; k++) begin
            diff = longint'($signed(held_xyz[0][k])) - longint'($signed(held_xyz[1][k]));
            mag = (diff < 0) ? 64'(-diff) : 64'(diff);
            if (mag >= 64'h8000_0000) return 1'b1;
            total = total + mag * mag;
        end
        return (total >= lim2);
    endfunction

    // Expected status after one sampled request.
    function automatic out_t predict_alert_status(in_t d);
        out_t res;
        if (d.strobe_a != lane_strobe[0]) begin
            lane_strobe[0] = d.strobe_a;
            lane_take_byte(0, d.byte_a);
        end
        if (d.strobe_b != lane_strobe[1]) begin
            lane_strobe[1] = d.strobe_b;
            lane_take_byte(1, d.byte_b);
        end
        res.alarm = divergence_alarm();
        res.fix_a = fix_seen[0];
        res.fix_b = fix_seen[1];
        return res;
    endfunction

    // Build one NAV-SOL frame, then damage it as the kind asks.
    function automatic byte_q_t ubx_frame(frame_kind_e kind, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
        byte_q_t     f;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  fix_type;
        logic [31:0] word;
        int          idx;
        int          cut;
        fix_type = 8'($urandom_range(FIX_MIN, FIX_MAX));
        if (kind == FRM_BAD_FIX) begin
            case ($urandom_range(0, 2))
                0: fix_type = 8'd0;
                1: fix_type = 8'd1;
                default: fix_type = 8'($urandom_range(5, 255));
            endcase
        end
        f.push_back(UBX_SYNC1);
        f.push_back(UBX_SYNC2);
        f.push_back(UBX_CLASS);
        f.push_back(UBX_ID);
        f.push_back(UBX_LEN_LO);
        f.push_back(UBX_LEN_HI);
        for (int i = POS_PAY; i <= POS_PAY_LAST; i++) begin
            if (i == POS_FIX) begin
                f.push_back(fix_type);
            end else if (i >= POS_X && i <= POS_XYZ_END) begin
                idx = i - POS_X;
                word = (idx < 4) ? x : (idx < 8) ? y : z;
                f.push_back(word[8 * (idx % 4) +: 8]);
            end else begin
                f.push_back(8'($urandom));
            end
        end
        ck_a = '0;
        ck_b = '0;
        for (int i = POS_CLASS; i <= POS_PAY_LAST; i++) begin
            ck_a = ck_a + f[i];
            ck_b = ck_b + ck_a;
        end
        f.push_back(ck_a);
        f.push_back(ck_b);
        case (kind)
            FRM_BAD_HDR: begin
                idx = $urandom_range(POS_SYNC1, POS_LEN_HI);
                f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
            end
            FRM_BAD_CKA: f[POS_CKA] = f[POS_CKA] ^ 8'($urandom_range(1, 255));
            FRM_BAD_CKB: f[POS_CKB] = f[POS_CKB] ^ 8'($urandom_range(1, 255));
            FRM_CUT: begin
                cut = $urandom_range(1, POS_CKB);
                while (f.size() > cut) void'(f.pop_back());
            end
            default: ;
        endcase
        return f;
    endfunction

    function automatic frame_kind_e pick_frame_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return FRM_GOOD;
        if (roll < 68) return FRM_BAD_HDR;
        if (roll < 76) return FRM_BAD_FIX;
        if (roll < 84) return FRM_BAD_CKA;
        if (roll < 92) return FRM_BAD_CKB;
        return FRM_CUT;
    endfunction

    // Queue one sampled request; a toggle marks a new byte on that lane.
    task automatic push_sample(logic [7:0] ba, bit ta, logic [7:0] bb, bit tb);
        in_t d;
        if (ta) strobe_a_level = ~strobe_a_level;
        if (tb) strobe_b_level = ~strobe_b_level;
        d.byte_a   = ba;
        d.strobe_a = strobe_a_level;
        d.byte_b   = bb;
        d.strobe_b = strobe_b_level;
        pending_samples.push_back(d);
        samples_sent++;
        if (ta || tb) new_byte_samples++;
    endtask

    // Pick two positions (near the threshold, at range ends or equal), then frame them.
    task automatic append_frame_pair(logic [30:0] thr);
        longint      pos_a[3];
        longint      pos_b[3];
        longint      off;
        longint      room;
        longint      span;
        longint      mult;
        longint      swap;
        int unsigned axis;
        frame_kind_e kind_a;
        frame_kind_e kind_b;
        byte_q_t     fa;
        byte_q_t     fb;
        for (int i = 0; i < 3; i++) begin
            pos_a[i] = longint'($signed($urandom));
            pos_b[i] = pos_a[i];
        end
        case ($urandom_range(0, 4))
            // One axis apart by threshold-1 .. threshold+2.
            0: begin
                off = longint'(thr) + longint'($urandom_range(0, 3)) - 1;
                if (off < 0) off = 0;
                room = 64'sd4294967295 - off;
                axis = $urandom_range(0, 2);
                pos_a[axis] = -64'sd2147483648 + longint'({$urandom, $urandom} % (room + 1));
                pos_b[axis] = pos_a[axis] + off;
                if ($urandom_range(0, 1) == 1) begin
                    swap = pos_a[axis];
                    pos_a[axis] = pos_b[axis];
                    pos_b[axis] = swap;
                end
            end
            // Random offsets on all three axes on the scale of the threshold.
            1: begin
                span = (longint'(thr) > HALF_RANGE) ? HALF_RANGE : longint'(thr);
                for (int i = 0; i < 3; i++) begin
                    pos_a[i] = longint'($signed($urandom)) >>> 1;
                    pos_b[i] = pos_a[i] + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
                end
            end
            // 2-3-6 offsets give an exact distance of seven steps.
            2: begin
                mult = longint'(thr) / 7 + longint'($urandom_range(0, 1));
                if (mult > HALF_RANGE / 6) mult = HALF_RANGE / 6;
                for (int i = 0; i < 3; i++) begin
                    pos_a[i] = longint'($signed($urandom)) >>> 1;
                    off = mult * ((i == 0) ? 2 : (i == 1) ? 3 : 6);
                    pos_b[i] = ($urandom_range(0, 1) == 1) ? pos_a[i] + off : pos_a[i] - off;
                end
            end
            // Coordinates at the ends of the signed range, at zero or random.
            3: begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0: pos_a[i] = -64'sd2147483648;
                        1: pos_a[i] = 64'sd2147483647;
                        2: pos_a[i] = 0;
                        default: ;
                    endcase
                    case ($urandom_range(0, 3))
                        0: pos_b[i] = -64'sd2147483648;
                        1: pos_b[i] = 64'sd2147483647;
                        2: pos_b[i] = 0;
                        default: pos_b[i] = longint'($signed($urandom));
                    endcase
                end
            end
            default: ;
        endcase
        kind_a = pick_frame_kind();
        kind_b = pick_frame_kind();
        if (kind_a == FRM_GOOD) frames_good++; else frames_broken++;
        if (kind_b == FRM_GOOD) frames_good++; else frames_broken++;
        fa = ubx_frame(kind_a, 32'(pos_a[0]), 32'(pos_a[1]), 32'(pos_a[2]));
        fb = ubx_frame(kind_b, 32'(pos_b[0]), 32'(pos_b[1]), 32'(pos_b[2]));
        foreach (fa[i]) lane_a_bytes.push_back(fa[i]);
        foreach (fb[i]) lane_b_bytes.push_back(fb[i]);
        // Occasional line noise between frames.
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) lane_a_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) lane_b_bytes.push_back(8'($urandom));
        end
    endtask

    // Serialize both lane streams, each lane toggling on most samples.
    task automatic serialize_lanes();
        bit         ta;
        bit         tb;
        logic [7:0] ba;
        logic [7:0] bb;
        while (lane_a_bytes.size() != 0 || lane_b_bytes.size() != 0) begin
            ta = lane_a_bytes.size() != 0 && $urandom_range(0, 99) < 75;
            tb = lane_b_bytes.size() != 0 && $urandom_range(0, 99) < 75;
            ba = ta ? lane_a_bytes.pop_front() : 8'($urandom);
            bb = tb ? lane_b_bytes.pop_front() : 8'($urandom);
            push_sample(ba, ta, bb, tb);
        end
    endtask

    // Wait until every queued request has produced its checked result.
    task automatic wait_drained();
        while (results_seen < samples_sent) @(posedge aclk);
    endtask

    // Request driver with prediction at acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predicted_status.push_back(predict_alert_status(s_data));
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_samples.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no prediction pending: alarm %0b fix_a %0b fix_b %0b",
                                 $realtime, m_data.alarm, m_data.fix_a, m_data.fix_b);
                end else begin
                    mon_want = predicted_status.pop_front();
                    if (mon_want.alarm) alarms_seen++;
                    if (m_data.alarm !== mon_want.alarm || m_data.fix_a !== mon_want.fix_a ||
                        m_data.fix_b !== mon_want.fix_b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d mismatch: alarm %0b/%0b fix_a %0b/%0b fix_b %0b/%0b (expected/actual)",
                                     $realtime, results_seen, mon_want.alarm, m_data.alarm,
                                     mon_want.fix_a, m_data.fix_a, mon_want.fix_b, m_data.fix_b);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ubx_dual_position_divergence_alert_unit verification failed");
            $finish;
        end
    end

    // Stimulus sequencing: reset, directed samples, then phased random frames.
    initial begin
        logic [30:0] thr;
        int unsigned target;
        alert_cm_model = ALERT_RESET;
        for (int r = 0; r < 2; r++) begin
            lane_strobe[r] = 1'b0;
            frame_pos[r]   = POS_SYNC1;
            sum_a[r]       = '0;
            sum_b[r]       = '0;
            fix_seen[r]    = 1'b0;
            for (int k = 0; k < 3; k++) begin
                partial_xyz[r][k] = '0;
                held_xyz[r][k]    = '0;
            end
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 19;
        stall_pct     = 79;

        // Directed samples: byte extremes, held strobes and a broken header at each step.
        push_sample(8'h00, 1'b0, 8'hFF, 1'b0);
        push_sample(8'hFF, 1'b1, 8'h00, 1'b1);
        push_sample(UBX_SYNC1, 1'b1, UBX_SYNC1, 1'b1);
        push_sample(UBX_SYNC2, 1'b1, 8'h61, 1'b1);
        push_sample(8'h02, 1'b1, UBX_SYNC1, 1'b1);
        push_sample(UBX_SYNC1, 1'b1, UBX_SYNC2, 1'b1);
        push_sample(UBX_SYNC2, 1'b1, 8'h07, 1'b1);
        push_sample(UBX_CLASS, 1'b1, 8'hAA, 1'b0);
        push_sample(8'h05, 1'b1, UBX_SYNC1, 1'b1);
        push_sample(UBX_SYNC1, 1'b1, UBX_SYNC2, 1'b1);
        push_sample(UBX_SYNC2, 1'b1, UBX_CLASS, 1'b1);
        push_sample(UBX_CLASS, 1'b1, UBX_ID, 1'b1);
        push_sample(UBX_ID, 1'b1, 8'd53, 1'b1);
        push_sample(UBX_LEN_LO, 1'b1, 8'h55, 1'b0);
        push_sample(8'h01, 1'b1, 8'h00, 1'b0);
        push_sample(8'hFF, 1'b0, 8'h00, 1'b0);

        // Six phases; each ends with the pipeline fully drained.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 19;
                stall_pct     = 79;
            end else if (phase < 4) begin
                send_idle_pct = 79;
                stall_pct     = 19;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            if (phase != 0) begin
                case (phase)
                    1: thr = 31'd0;
                    2: thr = 31'h7FFF_FFFF;
                    3: thr = 31'($urandom_range(1, 1000));
                    4: thr = 31'($urandom);
                    default: thr = 31'(7 * $urandom_range(1, 20000) - 1);
                endcase
                wait_drained();
                repeat (8) @(posedge aclk);
                cfg_wdata <= thr;
                cfg_we    <= 1'b1;
                @(posedge aclk);
                cfg_we    <= 1'b0;
                alert_cm_model = thr;
            end
            target = new_byte_samples + PHASE_NEW_BYTES;
            while (new_byte_samples < target) begin
                append_frame_pair(alert_cm_model);
                serialize_lanes();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d requests (%0d with a new byte) under six thresholds from 0 to 2^31-1.",
                 samples_sent, new_byte_samples);
        $display("Frames: %0d intact, %0d corrupted or cut; alarm expected in %0d of %0d results.",
                 frames_good, frames_broken, alarms_seen, results_seen);
        if (mismatches == 0 && predicted_status.size() == 0) begin
            $display("ubx_dual_position_divergence_alert_unit verification clean");
        end else begin
            $display("ubx_dual_position_divergence_alert_unit verification failed");
        end
        $finish;
    end

endmodule
